// File: src/aes128_ctr_cipher_unit_defines.svh
// Assertion macros shared by the cipher unit RTL.
`ifndef AES128_CTR_CIPHER_UNIT_DEFINES_SVH
`define AES128_CTR_CIPHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// File: src/aesctr_pkg.sv
// Package: AES constants, S-box and round helper functions.
`timescale 1ns / 1ps
package aesctr_pkg;
   localparam int ROUNDS = 10;
   localparam int NKEYS = ROUNDS + 1;
   localparam int DEPTH = ROUNDS + 2;

   typedef enum logic [1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW = 2'd1,
      REG_IV = 2'd2,
      REG_NONCE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [127:0] state;
      logic [127:0] rkey;
      logic [127:0] data;
   } cell_data_type;

   function automatic logic [7:0] sbox(input logic [7:0] b);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[b];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8 * (r + 4 * c) -: 8] = sbox(get_byte(s, r + 4 * ((c + r) % 4)));
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4 * c);
         a1 = get_byte(s, 4 * c + 1);
         a2 = get_byte(s, 4 * c + 2);
         a3 = get_byte(s, 4 * c + 3);
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // next round key from the previous one and its round constant
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction
endpackage

// File: src/aesctr_stream_if.sv
// Valid/ready stream interfaces for request and response beats.
`timescale 1ns / 1ps
interface aesctr_req_if;
   logic valid;
   logic ready;
   logic first_block;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, first_block, data_high, data_low, input ready);
   modport sink (input valid, first_block, data_high, data_low, output ready);
endinterface

interface aesctr_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] out_high;
   logic [63:0] out_low;
   modport source (output valid, out_high, out_low, input ready);
   modport sink (input valid, out_high, out_low, output ready);
endinterface

// File: src/aesctr_round_cell.sv
// One cipher round cell: round on the state and expands the next round key.
`timescale 1ns / 1ps
module aesctr_round_cell (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [7:0]                rcon,
   input  logic                      last_round,
   input  aesctr_pkg::cell_data_type cell_in,
   output aesctr_pkg::cell_data_type cell_out
);
   import aesctr_pkg::*;

   cell_data_type cell_ff, cell_in_w;
   logic [127:0] key_w, sub_w;

   always_comb begin
      key_w = next_key(cell_in.rkey, rcon);
      sub_w = sub_shift(cell_in.state);
      cell_in_w.rkey = key_w;
      cell_in_w.data = cell_in.data;
      cell_in_w.state = (last_round ? sub_w : mix_columns(sub_w)) ^ key_w;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;
endmodule

// File: src/aes128_ctr_cipher_unit.sv
// Top level: AES-128 counter-mode cipher, one block per cycle when not stalled.
//
// Request channel (req_): one 128-bit data block per beat plus a first-block
// flag that restarts the block index. Response channel (rsp_): the block
// XORed with the keystream, one beat per request, in order.
// csr_ port: index 0/1 key halves, 2 IV, 3 nonce; the user must write it
// only while idle; the block itself does not enforce this. The round keys
// are expanded on the fly: each of the ten round cells carries the state
// and its round key to the next cell every cycle that the chain advances.
// From request beat to response valid there are twelve registers: counter
// stage, ten round cells, output register. Throughput: one beat per cycle
// unless stalled. The chain is a single stall domain: when the response is
// held and the output register is full, the whole chain freezes and
// req_ready drops. Reset clears the block index and all valid bits; keys,
// IV and nonce return to zero.
`timescale 1ns / 1ps
`include "aes128_ctr_cipher_unit_defines.svh"
module aes128_ctr_cipher_unit (
   input  logic         clock,
   input  logic         reset,
   aesctr_req_if.sink   req,
   aesctr_rsp_if.source rsp,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import aesctr_pkg::*;

   logic [63:0] key_high_ff, key_low_ff, iv_ff, block_index_ff, block_index_in;
   logic [31:0] nonce_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic advance, take_req;
   logic [63:0] ctr_w, idx_w;
   cell_data_type stage0_ff, stage0_in;
   cell_data_type chain [NKEYS];
   logic [127:0] out_ff;
   logic [7:0] rcon [ROUNDS];

   // chain moves unless the output register is full and held
   assign advance = !(valid_ff[DEPTH-1] && !rsp.ready);
   assign take_req = req.valid && req.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         iv_ff <= '0;
         nonce_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_wdata;
            REG_KEY_LOW: key_low_ff <= csr_wdata;
            REG_IV: iv_ff <= csr_wdata;
            REG_NONCE: nonce_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // counter stage: block index and counter block
   always_comb begin
      idx_w = req.first_block ? 64'd0 : block_index_ff;
      ctr_w = {iv_ff[31:0], 32'd0} + 64'd1 + idx_w;
      block_index_in = take_req ? idx_w + 64'd1 : block_index_ff;
      stage0_in.rkey = {key_high_ff, key_low_ff};
      stage0_in.data = {req.data_high, req.data_low};
      stage0_in.state = {nonce_ff, iv_ff[63:32], ctr_w} ^ {key_high_ff, key_low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_index_ff <= '0;
      end else begin
         block_index_ff <= block_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage0_ff <= stage0_in;
      end
   end

   assign chain[0] = stage0_ff;

   // round constants 01,02,..,80,1b,36
   always_comb begin
      rcon[0] = 8'h01;
      for (int i = 1; i < ROUNDS; i++) rcon[i] = xtime(rcon[i-1]);
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      aesctr_round_cell u_cell (
         .clock      (clock),
         .advance    (advance),
         .rcon       (rcon[r]),
         .last_round (r == ROUNDS - 1),
         .cell_in    (chain[r]),
         .cell_out   (chain[r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= chain[ROUNDS].state ^ chain[ROUNDS].data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = {valid_ff[DEPTH-2:0], take_req};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid = valid_ff[DEPTH-1];
   assign rsp.out_high = out_ff[127:64];
   assign rsp.out_low = out_ff[63:0];

   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(out_ff))
   `ASSERT_IMPLIES(a_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   `ASSERT_NEXT(a_first, clock, reset, take_req && req.first_block, block_index_ff == 64'd1)
   `ASSERT_NEXT(a_idle_idx, clock, reset, !take_req, $stable(block_index_ff))
endmodule

// File: sim/aes128_ctr_cipher_unit_tb.sv
// Self-checking bench for the AES-128 CTR cipher unit: stimulus table, random messages.
`timescale 1ns / 1ps
module aes128_ctr_cipher_unit_tb;
   import aesctr_pkg::*;

   // Watchdog: cycles with no beat on either channel before the run is abandoned.
   // The longest quiet stretch is the long response hold.
   localparam int STALL_LIMIT = 5000;
   // Margin after the last result before the verdict.
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_BEATS = 250;

   typedef struct {
      bit          first;
      logic [63:0] hi;
      logic [63:0] lo;
   } blk_row_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   aesctr_req_if req ();
   aesctr_rsp_if rsp ();

   aes128_ctr_cipher_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Cipher predictor: its own copy of the registers and block index.
   // ---------------------------------------------------------------
   logic [7:0]   sbox_lut [256];
   logic [127:0] sched [0:ROUNDS];
   logic [127:0] key_reg = '0;
   logic [63:0]  iv_reg = '0;
   logic [31:0]  nonce_reg = '0;
   logic [63:0]  msg_index = '0;

   cipher_out_type expected_blocks[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   bit sender_idles = 1'b1;
   bit recv_idles = 1'b1;
   bit hold_rsp = 1'b0;

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // S-box built from the field inverse and the affine map
   task automatic build_sbox();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         s = 8'h63;
         for (int n = 0; n < 5; n++)
            s ^= 8'((inv << n) | (inv >> (8 - n)));
         sbox_lut[x] = s;
      end
   endtask

   task automatic rebuild_schedule();
      logic [31:0] w [4];
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      sched[0] = key_reg;
      for (int r = 1; r <= ROUNDS; r++) begin
         for (int i = 0; i < 4; i++) w[i] = sched[r-1][127 - 32*i -: 32];
         t = {sbox_lut[w[3][23:16]] ^ rcon, sbox_lut[w[3][15:8]],
              sbox_lut[w[3][7:0]], sbox_lut[w[3][31:24]]};
         w[0] ^= t;
         for (int i = 1; i < 4; i++) w[i] ^= w[i-1];
         sched[r] = {w[0], w[1], w[2], w[3]};
         rcon = gf_mul(rcon, 8'h02);
      end
   endtask

   function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3, sum;
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ sched[0][127 - 8*i -: 8];
      for (int r = 1; r <= ROUNDS; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               tmp[w + 4*c] = sbox_lut[st[w + 4*((c + w) % 4)]];
         st = tmp;
         if (r != ROUNDS) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               sum = a0 ^ a1 ^ a2 ^ a3;
               st[4*c]   = a0 ^ sum ^ gf_mul(a0 ^ a1, 8'h02);
               st[4*c+1] = a1 ^ sum ^ gf_mul(a1 ^ a2, 8'h02);
               st[4*c+2] = a2 ^ sum ^ gf_mul(a2 ^ a3, 8'h02);
               st[4*c+3] = a3 ^ sum ^ gf_mul(a3 ^ a0, 8'h02);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= sched[r][127 - 8*i -: 8];
      end
      for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = st[i];
      return blk;
   endfunction

   // Counter block: nonce, IV bytes 0..3, then the 64-bit count (wraps naturally).
   task automatic predict_block(bit first, logic [63:0] hi, logic [63:0] lo);
      logic [63:0]  count;
      logic [127:0] pad;
      if (first) msg_index = '0;
      count = {iv_reg[31:0], 32'h0} + 64'd1 + msg_index;
      msg_index = msg_index + 64'd1;
      pad = aes_encrypt({nonce_reg, iv_reg[63:32], count});
      expected_blocks.push_back('{hi: pad[127:64] ^ hi, lo: pad[63:0] ^ lo});
   endtask

   // ---------------------------------------------------------------
   // Request-side monitor and response checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         predict_block(req.first_block, req.data_high, req.data_low);
   end

   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: %h %h", rsp.out_high, rsp.out_low);
         end else begin
            want = expected_blocks.pop_front();
            if (rsp.out_high !== want.hi || rsp.out_low !== want.lo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: exp %h %h got %h %h",
                           want.hi, want.lo, rsp.out_high, rsp.out_low);
            end
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold on request
   // ---------------------------------------------------------------
   initial begin
      rsp.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
            rsp.ready <= 1'b1;
         end else if (recv_idles && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic send_block(bit first, logic [63:0] hi, logic [63:0] lo);
      req.valid <= 1'b1;
      req.first_block <= first;
      req.data_high <= hi;
      req.data_low <= lo;
      do @(posedge clock); while (!req.ready);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Register writes go in only while idle; the write and the predictor move together.
   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_KEY_HIGH: begin key_reg[127:64] = value; rebuild_schedule(); end
         REG_KEY_LOW:  begin key_reg[63:0] = value; rebuild_schedule(); end
         REG_IV:       iv_reg = value;
         REG_NONCE:    nonce_reg = value[31:0];  // upper half is dropped
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      wait (expected_blocks.size() == 0);
      repeat (14) @(posedge clock);
   endtask

   task automatic load_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] iv,
                              logic [63:0] nonce);
      wait_drained();
      write_reg(REG_KEY_HIGH, kh);
      write_reg(REG_KEY_LOW, kl);
      write_reg(REG_IV, iv);
      write_reg(REG_NONCE, nonce);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random messages: each starts with the first-block flag, random length.
   task automatic random_messages(int beats, bit with_hold, bit with_pause);
      int sent;
      int len;
      sent = 0;
      while (sent < beats) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         for (int i = 0; i < len && sent < beats; i++) begin
            if (with_hold && sent == beats / 3) hold_rsp = 1'b1;
            if (with_pause && sent == beats / 2) wait_drained();
            send_block(i == 0, rand64(), rand64());
            sent++;
         end
      end
   endtask

   // Directed stimulus after reset (all-zero key, IV and nonce).
   // Partial final blocks appear as zero-padded tails.
   blk_row_type directed [] = '{
      '{1'b1, 64'h0, 64'h0},
      '{1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1},
      '{1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
      '{1'b0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001},
      '{1'b1, 64'h0, 64'h0},   // restart: must repeat the first keystream block
      '{1'b1, 64'h0, 64'h0},   // back-to-back restarts
      '{1'b0, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF},
      '{1'b0, 64'hDEAD_BEEF_0000_0000, 64'h0},  // short tail, padded
      '{1'b1, 64'h0102_0304_0506_0708, 64'h0},
      '{1'b0, 64'h0000_00FF_0000_0000, 64'h0},
      '{1'b0, '1, 64'h0},
      '{1'b0, 64'h0, '1}
   };

   initial begin
      req.valid = 1'b0;
      req.first_block = 1'b0;
      req.data_high = '0;
      req.data_low = '0;
      build_sbox();
      rebuild_schedule();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_block(directed[i].first, directed[i].hi, directed[i].lo);

      // Extremes: all-ones registers; IV low half at max puts the counter's upper half at all ones.
      load_config('1, '1, '1, '1);
      foreach (directed[i]) send_block(directed[i].first, directed[i].hi, directed[i].lo);
      random_messages(PHASE_BEATS, 1'b1, 1'b0);

      // Only the low half of the nonce write counts.
      load_config('0, '0, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
      random_messages(PHASE_BEATS, 1'b0, 1'b1);

      for (int p = 0; p < 3; p++) begin
         load_config(rand64(), rand64(), rand64(), rand64());
         random_messages(PHASE_BEATS, 1'b0, 1'b0);
      end

      // Final stretch at full rate on both sides.
      load_config(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F, rand64(), rand64());
      sender_idles = 1'b0;
      recv_idles = 1'b0;
      random_messages(PHASE_BEATS, 1'b0, 1'b0);

      req.valid <= 1'b0;
      wait (expected_blocks.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
